### hw/rtl/mcbd_pkg.sv
`timescale 1ns / 1ps

package mcbd_pkg;

   localparam int BUTTON_INDEX_W = 3;
   localparam int TIME_W         = 16;
   localparam int COUNT_W        = 4;
   localparam int KIND_W         = 2;
   localparam int PHASE_W        = 3;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 16;

   localparam logic [PHASE_W-1:0] PH_AWAIT_PRESS   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_DEB_PRESS     = 3'd1;
   localparam logic [PHASE_W-1:0] PH_AWAIT_RELEASE = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DEB_RELEASE   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_AWAIT_MULTI   = 3'd4;

   localparam logic [KIND_W-1:0] EV_NONE          = 2'd0;
   localparam logic [KIND_W-1:0] EV_HOLD          = 2'd1;
   localparam logic [KIND_W-1:0] EV_HOLD_RELEASED = 2'd2;
   localparam logic [KIND_W-1:0] EV_CLICKS        = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_MASK         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BUTTONS_IN_USE      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_PRESS_MS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_RELEASE_MS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD_MS             = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MULTI_CLICK_MS      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_CLICKS          = 3'd6;

   typedef struct packed {
      logic [7:0]        active_mask;
      logic [3:0]        buttons_in_use;
      logic [TIME_W-1:0] debounce_press_ms;
      logic [TIME_W-1:0] debounce_release_ms;
      logic [TIME_W-1:0] hold_ms;
      logic [TIME_W-1:0] multi_click_ms;
      logic [COUNT_W-1:0] max_clicks;
   } mcbd_cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [COUNT_W-1:0] click_tally;
      logic               hold_mark;
      logic [TIME_W-1:0]  event_timer;
   } btn_state_type;

endpackage

### hw/rtl/mcbd_if.sv
`timescale 1ns / 1ps

interface mcbd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  button_index;
   logic        level;
   logic [15:0] elapsed_ms;

   modport source (output valid, output button_index, output level, output elapsed_ms,
                   input ready);
   modport sink   (input valid, input button_index, input level, input elapsed_ms,
                   output ready);
endinterface

interface mcbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_button;
   logic [1:0] event_kind;
   logic [3:0] click_count;

   modport source (output valid, output event_button, output event_kind,
                   output click_count, input ready);
   modport sink   (input valid, input event_button, input event_kind,
                   input click_count, output ready);
endinterface

### hw/rtl/mcbd_csr.sv
`timescale 1ns / 1ps

module mcbd_csr
   import mcbd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output mcbd_cfg_type           cfg
);

   mcbd_cfg_type cfg_ff;
   mcbd_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_ACTIVE_MASK:         cfg_in.active_mask         = csr_wdata[7:0];
            REG_BUTTONS_IN_USE:      cfg_in.buttons_in_use      = csr_wdata[3:0];
            REG_DEBOUNCE_PRESS_MS:   cfg_in.debounce_press_ms   = csr_wdata;
            REG_DEBOUNCE_RELEASE_MS: cfg_in.debounce_release_ms = csr_wdata;
            REG_HOLD_MS:             cfg_in.hold_ms             = csr_wdata;
            REG_MULTI_CLICK_MS:      cfg_in.multi_click_ms      = csr_wdata;
            REG_MAX_CLICKS:          cfg_in.max_clicks          = csr_wdata[COUNT_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_mask         <= 8'd0;
         cfg_ff.buttons_in_use      <= 4'd0;
         cfg_ff.debounce_press_ms   <= 16'd15;
         cfg_ff.debounce_release_ms <= 16'd30;
         cfg_ff.hold_ms             <= 16'd2000;
         cfg_ff.multi_click_ms      <= 16'd400;
         cfg_ff.max_clicks          <= 4'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/mcbd_bank.sv
`timescale 1ns / 1ps

module mcbd_bank
   import mcbd_pkg::*;
#(
   parameter int BUTTONS = 8
)(
   input  logic                      clock,
   input  logic                      reset,
   input  mcbd_cfg_type              cfg,
   input  logic                      fire,
   input  logic [BUTTON_INDEX_W-1:0] button_index,
   input  logic                      level,
   input  logic [TIME_W-1:0]         elapsed_ms,
   output logic [KIND_W-1:0]         event_kind,
   output logic [COUNT_W-1:0]        click_count
);

   localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

   btn_state_type state_ff [BUTTONS];

   logic              in_use;
   logic [IDX_W-1:0]  idx;
   btn_state_type     cur;
   btn_state_type     nxt;
   logic              pressed;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] t;
   logic [COUNT_W:0]  tally_inc;

   assign in_use = ({1'b0, button_index} < cfg.buttons_in_use)
                   && (int'(button_index) < BUTTONS);
   assign idx     = IDX_W'(button_index);
   assign cur     = in_use ? state_ff[idx] : '0;
   assign pressed = (level == cfg.active_mask[button_index]);
   assign sum     = {1'b0, cur.event_timer} + {1'b0, elapsed_ms};
   assign t       = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   assign tally_inc = {1'b0, cur.click_tally} + 1'b1;

   always_comb begin
      nxt             = cur;
      nxt.event_timer = t;
      event_kind      = EV_NONE;
      click_count     = '0;
      unique case (cur.phase)
         PH_DEB_PRESS: begin
            if (t > cfg.debounce_press_ms) begin
               nxt.phase       = PH_AWAIT_RELEASE;
               nxt.event_timer = '0;
            end
         end
         PH_AWAIT_RELEASE: begin
            if (!pressed) begin
               nxt.phase       = PH_DEB_RELEASE;
               nxt.event_timer = '0;
            end else if (t > cfg.hold_ms) begin
               nxt.hold_mark   = 1'b1;
               nxt.event_timer = '0;
               event_kind      = EV_HOLD;
            end
         end
         PH_DEB_RELEASE: begin
            if (t > cfg.debounce_release_ms) begin
               if (cur.hold_mark) begin
                  nxt.phase  = PH_AWAIT_PRESS;
                  event_kind = EV_HOLD_RELEASED;
               end else begin
                  nxt.click_tally = (tally_inc > {1'b0, cfg.max_clicks})
                                    ? cfg.max_clicks : tally_inc[COUNT_W-1:0];
                  nxt.phase       = PH_AWAIT_MULTI;
                  nxt.event_timer = '0;
               end
            end
         end
         PH_AWAIT_MULTI: begin
            if (pressed) begin
               nxt.phase       = PH_DEB_PRESS;
               nxt.event_timer = '0;
            end else if (t > cfg.multi_click_ms) begin
               nxt.phase   = PH_AWAIT_PRESS;
               event_kind  = EV_CLICKS;
               click_count = cur.click_tally;
            end
         end
         default: begin
            nxt.click_tally = '0;
            nxt.hold_mark   = 1'b0;
            nxt.phase       = PH_AWAIT_PRESS;
            if (pressed) begin
               nxt.phase       = PH_DEB_PRESS;
               nxt.event_timer = '0;
            end
         end
      endcase
      if (!in_use) begin
         event_kind  = EV_NONE;
         click_count = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTONS; i++) begin
            state_ff[i] <= '{phase: PH_AWAIT_PRESS, click_tally: '0,
                             hold_mark: 1'b0, event_timer: '0};
         end
      end else if (fire && in_use) begin
         state_ff[idx] <= nxt;
      end
   end

endmodule

### hw/rtl/multi_click_button_detector.sv
`timescale 1ns / 1ps
// Multi-click and hold detector for push buttons.
// req_chan: one request per button sample (button index, sampled level, ms since
//   that button's previous sample). rsp_chan: exactly one result per request, in
//   order: the button index, the event kind (none, hold, hold released, click run
//   ended) and the click count of a finished run.
// csr_*: write-only register port; write only while no request is in flight.
// A request in the input register moves on to the result register, which loads
//   the per-button state update, when no result is held or it is taken.
// Throughput: one request per cycle unless the result stalls, also for the same
//   button back to back, as the state bank is read and written in the same cycle
//   as the result register.
// Reset: every button returns to await press with cleared count, hold mark and
//   timer; registers take their defaults; no result is pending.
// Stall: while rsp_chan.ready is low the result holds, one more request is taken
//   into the input register, and then req_chan.ready drops.

module multi_click_button_detector
   import mcbd_pkg::*;
#(
   parameter int BUTTONS = 8
)(
   input  logic                   clock,
   input  logic                   reset,
   mcbd_req_if.sink               req_chan,
   mcbd_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   mcbd_cfg_type cfg;

   logic                      stage_valid_ff;
   logic [BUTTON_INDEX_W-1:0] stage_index_ff;
   logic                      stage_level_ff;
   logic [TIME_W-1:0]         stage_elapsed_ff;

   logic                      rsp_valid_ff;
   logic [BUTTON_INDEX_W-1:0] rsp_button_ff;
   logic [KIND_W-1:0]         rsp_kind_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   logic                      advance;
   logic                      fire;
   logic                      accept;
   logic [KIND_W-1:0]         kind;
   logic [COUNT_W-1:0]        count;

   mcbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mcbd_bank #(.BUTTONS(BUTTONS)) u_bank (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .fire         (fire),
      .button_index (stage_index_ff),
      .level        (stage_level_ff),
      .elapsed_ms   (stage_elapsed_ff),
      .event_kind   (kind),
      .click_count  (count)
   );

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = stage_valid_ff && advance;
   assign req_chan.ready = !stage_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         stage_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_index_ff   <= req_chan.button_index;
         stage_level_ff   <= req_chan.level;
         stage_elapsed_ff <= req_chan.elapsed_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_button_ff <= stage_index_ff;
         rsp_kind_ff   <= kind;
         rsp_count_ff  <= count;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.event_button = rsp_button_ff;
   assign rsp_chan.event_kind   = rsp_kind_ff;
   assign rsp_chan.click_count  = rsp_count_ff;

endmodule

### hw/rtl/mcbd_checker.sv
`timescale 1ns / 1ps

module mcbd_checker
   import mcbd_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [BUTTON_INDEX_W-1:0] rsp_event_button,
   input logic [KIND_W-1:0]         rsp_event_kind,
   input logic [COUNT_W-1:0]        rsp_click_count
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_count_only_on_clicks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind != EV_CLICKS) |-> rsp_click_count == '0)
      else $error("click count set on an event other than click run ended");

   a_request_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> ##1 rsp_valid)
      else $error("accepted request did not reach the result register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_event_button)
                                     && $stable(rsp_event_kind)
                                     && $stable(rsp_click_count)))
      else $error("stalled result changed");

endmodule

bind multi_click_button_detector mcbd_checker u_mcbd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_event_button (rsp_chan.event_button),
   .rsp_event_kind   (rsp_chan.event_kind),
   .rsp_click_count  (rsp_chan.click_count)
);
